// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define CMH_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define CMH_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== src/cmh_pkg.sv =====
// Shared types, constants and helpers of the chained MurmurHash2 unit
package cmh_pkg;

	localparam int WORD_W   = 32;
	localparam int BYTES_W  = 3;
	localparam int LEN_W    = 31;
	localparam int CFG_IDX_W = 2;

	localparam logic [WORD_W-1:0] MIX_M = 32'h5bd1e995;
	localparam int MIX_R = 24;
	localparam int FIN_A = 13;
	localparam int FIN_B = 15;

	localparam logic [WORD_W-1:0] SEED_RESET = 32'hcbf29ce4;
	localparam logic [WORD_W-1:0] NULL_RESET = 32'h0a0b0c0d;
	localparam logic [WORD_W-1:0] NULL_LEN   = 32'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NULL_PATTERN = 2'd1;

	// datapath operations, one per cycle
	typedef enum logic [2:0] {
		OP_NONE,
		OP_K1,    // k = k * m
		OP_K2,    // k = (k ^ k >> r) * m
		OP_HM,    // h = h * m ^ k
		OP_TAIL,  // h = (h ^ k) * m, k holds the masked tail bytes
		OP_FIN1,  // h = (h ^ h >> 13) * m
		OP_FIN2   // h = h ^ h >> 15, result register loaded
	} cmh_op_t;

	typedef struct packed {
		logic    load;
		cmh_op_t op;
	} cmh_cmd_t;

	typedef struct packed {
		logic in_full;
		logic in_tail;
		logic in_last;
		logic last_q;
	} cmh_status_t;

	// keeps the valid low bytes of a word; five to seven count as four
	function automatic logic [WORD_W-1:0] byte_mask(input logic [BYTES_W-1:0] n);
		logic [WORD_W-1:0] m;
		m = '0;
		if (n[2]) begin
			m = '1;
		end else begin
			unique case (n[1:0])
				2'd0: m = 32'h0000_0000;
				2'd1: m = 32'h0000_00ff;
				2'd2: m = 32'h0000_ffff;
				2'd3: m = 32'h00ff_ffff;
				default: m = '0;
			endcase
		end
		return m;
	endfunction

endpackage

// ===== src/cmh_if.sv =====
// Channel interfaces: argument words, hash results and configuration writes
interface cmh_in_if;
	logic                            valid;
	logic                            ready;
	logic [cmh_pkg::WORD_W-1:0]      data_word;
	logic [cmh_pkg::BYTES_W-1:0]     word_bytes;
	logic                            first_word;
	logic                            last_word;
	logic [cmh_pkg::LEN_W-1:0]       arg_length;
	logic                            first_arg;
	logic                            last_arg;
	logic                            is_null;

	modport source (output valid, data_word, word_bytes, first_word, last_word,
		arg_length, first_arg, last_arg, is_null, input ready);
	modport sink (input valid, data_word, word_bytes, first_word, last_word,
		arg_length, first_arg, last_arg, is_null, output ready);
endinterface

interface cmh_out_if;
	logic                       valid;
	logic                       ready;
	logic [cmh_pkg::WORD_W-1:0] hash_value;
	logic                       row_done;

	modport source (output valid, hash_value, row_done, input ready);
	modport sink (input valid, hash_value, row_done, output ready);
endinterface

interface cmh_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [cmh_pkg::CFG_IDX_W-1:0] index;
	logic [cmh_pkg::WORD_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/cmh_dp.sv =====
// Datapath: hash and key registers, shared multiplier, config and result registers
module cmh_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmh_pkg::cmh_cmd_t             cmd,
	output cmh_pkg::cmh_status_t          st,
	input  logic [cmh_pkg::WORD_W-1:0]    data_word,
	input  logic [cmh_pkg::BYTES_W-1:0]   word_bytes,
	input  logic                          first_word,
	input  logic                          last_word,
	input  logic [cmh_pkg::LEN_W-1:0]     arg_length,
	input  logic                          first_arg,
	input  logic                          last_arg,
	input  logic                          is_null,
	input  logic                          cfg_we,
	input  logic [cmh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cmh_pkg::WORD_W-1:0]    cfg_data,
	output logic [cmh_pkg::WORD_W-1:0]    hash_value,
	output logic                          row_done
);
	import cmh_pkg::*;

	logic [WORD_W-1:0] seed_q, null_q, h_q, k_q, chain_q, res_q;
	logic              last_q, row_q, res_row_q;
	logic [WORD_W-1:0] seed_sel, mul_a, prod, fin2;

	assign st.in_full = is_null | word_bytes[2];
	assign st.in_tail = !is_null && !word_bytes[2] && (word_bytes[1:0] != 2'd0);
	assign st.in_last = is_null | last_word;
	assign st.last_q  = last_q;

	assign seed_sel = first_arg ? seed_q : chain_q;
	assign fin2     = h_q ^ (h_q >> FIN_B);

	// single multiplier by m, operand chosen by the current operation
	always_comb begin
		unique case (cmd.op)
			OP_K1:   mul_a = k_q;
			OP_K2:   mul_a = k_q ^ (k_q >> MIX_R);
			OP_TAIL: mul_a = h_q ^ k_q;
			OP_FIN1: mul_a = h_q ^ (h_q >> FIN_A);
			default: mul_a = h_q;
		endcase
	end
	assign prod = WORD_W'(mul_a * MIX_M);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= SEED_RESET;
			null_q  <= NULL_RESET;
			h_q     <= '0;
			chain_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_INITIAL_SEED) seed_q <= cfg_data;
				if (cfg_index == REG_NULL_PATTERN) null_q <= cfg_data;
			end
			if (cmd.load) begin
				if (is_null) begin
					h_q <= seed_sel ^ NULL_LEN;
				end else if (first_word) begin
					h_q <= seed_sel ^ {1'b0, arg_length};
				end
			end else begin
				unique case (cmd.op)
					OP_HM:   h_q <= prod ^ k_q;
					OP_TAIL: h_q <= prod;
					OP_FIN1: h_q <= prod;
					OP_FIN2: begin
						h_q     <= fin2;
						chain_q <= fin2;
					end
					default: h_q <= h_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k_q    <= is_null ? null_q : (data_word & byte_mask(word_bytes));
			last_q <= is_null | last_word;
			row_q  <= last_arg;
		end else if (cmd.op == OP_K1 || cmd.op == OP_K2) begin
			k_q <= prod;
		end
		if (cmd.op == OP_FIN2) begin
			res_q     <= fin2;
			res_row_q <= row_q;
		end
	end

	assign hash_value = res_q;
	assign row_done   = res_row_q;

endmodule

// ===== src/cmh_ctrl.sv =====
// Controller: sequences the shared multiplier and owns the input and output handshakes
module cmh_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  cmh_pkg::cmh_status_t st,
	output cmh_pkg::cmh_cmd_t    cmd
);
	import cmh_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_K1   = 3'd1;
	localparam logic [2:0] S_K2   = 3'd2;
	localparam logic [2:0] S_HM   = 3'd3;
	localparam logic [2:0] S_TAIL = 3'd4;
	localparam logic [2:0] S_FIN1 = 3'd5;
	localparam logic [2:0] S_FIN2 = 3'd6;

	logic [2:0] state_q, state_d;
	logic       out_valid_q, accept, res_fire;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	// result register may be reloaded as it drains
	assign res_fire  = (state_q == S_FIN2) && (!out_valid_q || out_ready);

	always_comb begin
		state_d  = state_q;
		cmd.load = accept;
		cmd.op   = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority if (st.in_full) state_d = S_K1;
					else if (st.in_tail)     state_d = S_TAIL;
					else if (st.in_last)     state_d = S_FIN1;
					else                     state_d = S_IDLE;
				end
			end
			S_K1: begin
				cmd.op  = OP_K1;
				state_d = S_K2;
			end
			S_K2: begin
				cmd.op  = OP_K2;
				state_d = S_HM;
			end
			S_HM: begin
				cmd.op  = OP_HM;
				state_d = st.last_q ? S_FIN1 : S_IDLE;
			end
			S_TAIL: begin
				cmd.op  = OP_TAIL;
				state_d = st.last_q ? S_FIN1 : S_IDLE;
			end
			S_FIN1: begin
				cmd.op  = OP_FIN1;
				state_d = S_FIN2;
			end
			S_FIN2: begin
				if (res_fire) begin
					cmd.op  = OP_FIN2;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/chained_murmur2_hash_unit.sv =====
// Top level of the chained MurmurHash2 unit
// Hashes each argument of a row with 32-bit MurmurHash2; an argument's hash
// seeds the next one, the first argument of a row takes initial_seed.
// Channels: in_ch takes one 32-bit little-endian word per item with its flags,
// out_ch gives one hash per argument (after its last word or a null item),
// cfg_ch writes initial_seed (index 0) and null_pattern (index 1), always ready.
// One multiplier by m is shared, so words go through one at a time:
//   full word (or null item): steps K1, K2 and HM; partial word: the tail step;
//   empty word: no step. A last word adds the final mixing steps FIN1 and FIN2.
// Results sit in an output register, so new words are taken while a result
// waits; if out_ch stalls, a second finished hash holds the unit until the
// first is taken.
// Reset clears the running hash and chain seed to zero and reloads the
// configuration defaults; no clearing pass is needed.
module chained_murmur2_hash_unit (
	input logic      clk,
	input logic      arst_n,
	cmh_in_if.sink   in_ch,
	cmh_out_if.source out_ch,
	cmh_cfg_if.sink  cfg_ch
);
	import cmh_pkg::*;

	cmh_cmd_t    cmd;
	cmh_status_t st;

	assign cfg_ch.ready = 1'b1;

	cmh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.st        (st),
		.cmd       (cmd)
	);

	cmh_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.data_word  (in_ch.data_word),
		.word_bytes (in_ch.word_bytes),
		.first_word (in_ch.first_word),
		.last_word  (in_ch.last_word),
		.arg_length (in_ch.arg_length),
		.first_arg  (in_ch.first_arg),
		.last_arg   (in_ch.last_arg),
		.is_null    (in_ch.is_null),
		.cfg_we     (cfg_ch.valid),
		.cfg_index  (cfg_ch.index),
		.cfg_data   (cfg_ch.data),
		.hash_value (out_ch.hash_value),
		.row_done   (out_ch.row_done)
	);

endmodule

// ===== src/cmh_checker.sv =====
// Port-level checks of the chained MurmurHash2 unit, bound to the top level
`include "assert_macros.svh"

module cmh_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [cmh_pkg::BYTES_W-1:0]   word_bytes,
	input logic                          last_word,
	input logic                          is_null,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [cmh_pkg::WORD_W-1:0]    hash_value,
	input logic                          row_done,
	input logic                          cfg_ready
);
	import cmh_pkg::*;

	`CMH_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(hash_value) && $stable(row_done), "result changed while stalled")
	`CMH_ASSERT(a_no_early_result, $rose(out_valid) |-> !$past(in_valid && in_ready), "result right after an accepted item")
	`CMH_ASSERT(a_empty_word_fast, in_valid && in_ready && !is_null && !last_word && word_bytes == 3'd0 |=> in_ready, "empty middle word held the unit")
	`CMH_NEVER(a_cfg_ready, !cfg_ready, "configuration port not ready")

endmodule

bind chained_murmur2_hash_unit cmh_checker u_cmh_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.word_bytes (in_ch.word_bytes),
	.last_word  (in_ch.last_word),
	.is_null    (in_ch.is_null),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.hash_value (out_ch.hash_value),
	.row_done   (out_ch.row_done),
	.cfg_ready  (cfg_ch.ready)
);
